/* design/thv_pkg.sv */
package thv_pkg;

	// layout of a 15-instrument module file
	localparam int NUM_INSTRUMENTS = 15;
	localparam int NUM_ORDERS      = 128;
	localparam int TITLE_LEN       = 20;
	localparam int REC_LEN         = 30;

	// byte offset counter, saturating at its top value
	localparam int                 OFS_W   = 18;
	localparam logic [OFS_W-1:0]   OFS_MAX = '1;
	localparam logic [OFS_W-1:0]   TITLE_END = OFS_W'(TITLE_LEN);
	localparam logic [OFS_W-1:0]   HDR_END   = OFS_W'(TITLE_LEN + REC_LEN * NUM_INSTRUMENTS);
	localparam logic [OFS_W-1:0]   TEMPO_OFS = OFS_W'(TITLE_LEN + REC_LEN * NUM_INSTRUMENTS + 1);
	localparam logic [OFS_W-1:0]   PAT_OFS   =
		OFS_W'(TITLE_LEN + REC_LEN * NUM_INSTRUMENTS + 2 + NUM_ORDERS);

	// one pattern is 1024 bytes; block index of a pattern byte
	localparam int BLK_SHIFT = 10;
	localparam int BLK_W     = OFS_W - BLK_SHIFT;
	localparam int REC_W     = $clog2(REC_LEN);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// verdict codes
	localparam logic [4:0] ERR_NONE      = 5'd0;
	localparam logic [4:0] ERR_SHORT     = 5'd1;
	localparam logic [4:0] ERR_TITLE     = 5'd2;
	localparam logic [4:0] ERR_NAME      = 5'd3;
	localparam logic [4:0] ERR_SIZE      = 5'd4;
	localparam logic [4:0] ERR_FINETUNE  = 5'd5;
	localparam logic [4:0] ERR_VOLUME    = 5'd6;
	localparam logic [4:0] ERR_REPEAT    = 5'd7;
	localparam logic [4:0] ERR_REP_NOSMP = 5'd8;
	localparam logic [4:0] ERR_REPLEN    = 5'd9;
	localparam logic [4:0] ERR_TOTAL     = 5'd10;
	localparam logic [4:0] ERR_SONGLEN   = 5'd11;
	localparam logic [4:0] ERR_TEMPO     = 5'd12;
	localparam logic [4:0] ERR_ORDER     = 5'd13;
	localparam logic [4:0] ERR_SAMPLE    = 5'd14;
	localparam logic [4:0] ERR_PERIOD    = 5'd15;
	localparam logic [4:0] ERR_TRUNC     = 5'd16;

	// instrument record byte positions
	localparam logic [REC_W-1:0] RB_NAME_FIRST = REC_W'(1);
	localparam logic [REC_W-1:0] RB_NAME_LAST  = REC_W'(21);
	localparam logic [REC_W-1:0] RB_SIZE_HI    = REC_W'(22);
	localparam logic [REC_W-1:0] RB_SIZE_LO    = REC_W'(23);
	localparam logic [REC_W-1:0] RB_FINETUNE   = REC_W'(24);
	localparam logic [REC_W-1:0] RB_VOLUME     = REC_W'(25);
	localparam logic [REC_W-1:0] RB_REP_HI     = REC_W'(26);
	localparam logic [REC_W-1:0] RB_REP_LO     = REC_W'(27);
	localparam logic [REC_W-1:0] RB_LEN_HI     = REC_W'(28);
	localparam logic [REC_W-1:0] RB_LEN_LO     = REC_W'(29);

	// pattern event byte phases
	localparam logic [1:0] EV_NOTE_HI = 2'd0;
	localparam logic [1:0] EV_NOTE_LO = 2'd1;
	localparam logic [1:0] EV_EFFECT  = 2'd2;
	localparam logic [1:0] EV_PARAM   = 2'd3;

	// field limits
	localparam logic [15:0] SIZE_MAX     = 16'h8000;
	localparam logic [15:0] OLD_SIZE_MAX = 16'h1387;
	localparam logic [15:0] OLD_REP_MAX  = 16'd9999;
	localparam logic [15:0] SAMPLE_MASK  = 16'hF000;
	localparam logic [15:0] NEW_FX_MASK  = 16'hFFF9;
	localparam logic [7:0]  VOLUME_MAX   = 8'h40;
	localparam logic [7:0]  CHAR_LO      = 8'h20;
	localparam logic [7:0]  CHAR_HI      = 8'h7F;
	localparam logic [7:0]  TEMPO_MIN    = 8'h20;
	localparam logic [7:0]  ORDER_MAX    = 8'h7F;
	localparam logic [20:0] TOTAL_MIN    = 21'd8;

	typedef enum logic [2:0] {
		RG_TITLE,
		RG_INSTR,
		RG_SONGLEN,
		RG_TEMPO,
		RG_ORDER,
		RG_PATTERN
	} region_t;

	// one classified byte as it travels from front to back
	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		region_t          region;
		logic [REC_W-1:0] rec_pos;
		logic [1:0]       phase;
		logic [BLK_W-1:0] blk;
		logic             too_short;
		logic [BLK_W-1:0] end_blk;
	} item_t;

	function automatic logic printable(input logic [7:0] b);
		return (b >= CHAR_LO) && (b <= CHAR_HI);
	endfunction

	// note period table membership
	function automatic logic period_valid(input logic [15:0] p);
		logic hit;
		case (p)
			16'd856, 16'd808, 16'd762, 16'd720, 16'd678, 16'd640, 16'd604, 16'd570,
			16'd538, 16'd508, 16'd480, 16'd453, 16'd428, 16'd404, 16'd381, 16'd360,
			16'd339, 16'd320, 16'd302, 16'd285, 16'd269, 16'd254, 16'd240, 16'd226,
			16'd214, 16'd202, 16'd190, 16'd180, 16'd170, 16'd160, 16'd151, 16'd143,
			16'd135, 16'd127, 16'd120, 16'd113: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

/* design/tracker_module_header_validator_unit.sv */
// Checks a 15-instrument tracker module file streamed in one byte per transaction, with is_last
// on the final byte: title, instrument records, sample total, song length, tempo, order list
// and the pattern events up to the highest pattern used. The first failed check is latched and,
// after the final byte, one result transaction carries the verdict, the older-variant flag and
// the pattern count; all state then returns to its reset values for the next file. The block
// takes one byte every clock while the queue has room: the front counts the byte offset and
// classifies each byte, a two-entry queue decouples it from the back, which runs every check
// on one byte combinationally and holds the result in an output register. A final byte
// passes the queue and then the output register; while its result waits to be taken, later
// bytes keep flowing and only the next final byte is held back.
module tracker_module_header_validator_unit
	import thv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] verdict,
	output logic       is_old_variant,
	output logic [7:0] pattern_count
);

	logic  push;
	item_t push_item;
	logic  q_full;
	logic  q_valid;
	item_t q_item;
	logic  pop;

	// byte offset tracking and classification
	thv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.data_byte (data_byte),
		.is_last   (is_last),
		.q_full    (q_full),
		.in_stall  (in_stall),
		.push      (push),
		.push_item (push_item)
	);

	// queue between front and back
	thv_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (q_full),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	// checks and result
	thv_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict),
		.is_old_variant (is_old_variant),
		.pattern_count  (pattern_count)
	);

	// older-variant flag only on a clean verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == ERR_NONE || !is_old_variant))
		else $error("old variant flag set on a failed file");

	// verdict stays within its codes and pattern count is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict <= ERR_TRUNC && pattern_count != 8'd0))
		else $error("result transaction out of range");

	// a pop from the queue needs a filled queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("queue popped while empty");

endmodule

/* design/thv_front.sv */
module thv_front
	import thv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  [7:0] data_byte,
	input  logic  is_last,
	input  logic  q_full,
	output logic  in_stall,
	output logic  push,
	output item_t push_item
);

	logic [OFS_W-1:0] ofs_q;
	logic [REC_W-1:0] rec_q;
	logic [OFS_W-1:0] rel;
	logic [OFS_W:0]   nxt;
	logic [OFS_W:0]   nxt_rel;
	region_t          region;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// region decode from the byte offset
	always_comb begin
		if (ofs_q < TITLE_END) begin
			region = RG_TITLE;
		end else if (ofs_q < HDR_END) begin
			region = RG_INSTR;
		end else if (ofs_q == HDR_END) begin
			region = RG_SONGLEN;
		end else if (ofs_q == TEMPO_OFS) begin
			region = RG_TEMPO;
		end else if (ofs_q < PAT_OFS) begin
			region = RG_ORDER;
		end else begin
			region = RG_PATTERN;
		end
	end

	// pattern position of this byte and end position of the file
	assign rel     = ofs_q - PAT_OFS;
	assign nxt     = {1'b0, ofs_q} + (OFS_W+1)'(1);
	assign nxt_rel = nxt - {1'b0, PAT_OFS};

	always_comb begin
		push_item.data      = data_byte;
		push_item.last      = is_last;
		push_item.region    = region;
		push_item.rec_pos   = rec_q;
		push_item.phase     = rel[1:0];
		push_item.blk       = rel[BLK_SHIFT +: BLK_W];
		push_item.too_short = nxt < {1'b0, PAT_OFS};
		push_item.end_blk   = nxt_rel[BLK_SHIFT +: BLK_W];
	end

	// offset and record position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q <= '0;
			rec_q <= '0;
		end else if (push) begin
			if (is_last) begin
				ofs_q <= '0;
				rec_q <= '0;
			end else begin
				if (ofs_q != OFS_MAX) begin
					ofs_q <= ofs_q + OFS_W'(1);
				end
				if (region == RG_INSTR) begin
					if (rec_q == REC_W'(REC_LEN - 1)) begin
						rec_q <= '0;
					end else begin
						rec_q <= rec_q + REC_W'(1);
					end
				end
			end
		end
	end

endmodule

/* design/thv_fifo.sv */
module thv_fifo
	import thv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  q_valid,
	output item_t q_item
);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(QUEUE_DEPTH);
	assign q_valid = count_q != '0;
	assign q_item  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* design/thv_back.sv */
module thv_back
	import thv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] verdict,
	output logic       is_old_variant,
	output logic [7:0] pattern_count
);

	logic [7:0]  held_q;
	logic [15:0] size_q;
	logic [20:0] total_q;
	logic [6:0]  max_q;
	logic [15:0] eff_q;
	logic        old_q;
	logic [4:0]  fe_q;
	logic [3:0]  nib_q;

	logic [7:0]  held_n;
	logic [15:0] size_n;
	logic [20:0] total_n;
	logic [6:0]  max_n;
	logic [15:0] eff_n;
	logic        old_n;
	logic [4:0]  fe_n;
	logic [3:0]  nib_n;
	logic [4:0]  err;
	logic [4:0]  v;

	logic [7:0]  b;
	logic [15:0] w;
	logic [15:0] rep_half;
	logic [15:0] eff_bit;
	logic        out_free;

	logic        out_valid_q;
	logic [4:0]  verdict_q;
	logic        old_out_q;
	logic [7:0]  count_out_q;

	assign b        = q_item.data;
	assign w        = {held_q, b};
	assign rep_half = {1'b0, w[15:1]};
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = q_valid && (!q_item.last || out_free);

	// byte checks against the header layout and pattern events
	always_comb begin
		held_n  = held_q;
		size_n  = size_q;
		total_n = total_q;
		max_n   = max_q;
		eff_n   = eff_q;
		old_n   = old_q;
		nib_n   = nib_q;
		err     = ERR_NONE;
		eff_bit = '0;
		if (fe_q == ERR_NONE) begin
			case (q_item.region)
				RG_TITLE: begin
					if (!printable(b)) err = ERR_TITLE;
				end
				RG_INSTR: begin
					if (q_item.rec_pos >= RB_NAME_FIRST && q_item.rec_pos <= RB_NAME_LAST) begin
						if (!printable(b)) err = ERR_NAME;
					end else begin
						case (q_item.rec_pos)
							RB_SIZE_HI, RB_REP_HI, RB_LEN_HI: held_n = b;
							RB_SIZE_LO: begin
								size_n  = w;
								total_n = total_q + {4'd0, w, 1'b0};
								if (w > OLD_SIZE_MAX) old_n = 1'b0;
								if (w > SIZE_MAX) err = ERR_SIZE;
							end
							RB_FINETUNE: begin
								if (b != 8'd0) err = ERR_FINETUNE;
							end
							RB_VOLUME: begin
								if (b > VOLUME_MAX) err = ERR_VOLUME;
							end
							RB_REP_LO: begin
								if (w > OLD_REP_MAX) old_n = 1'b0;
								if (rep_half > size_q) begin
									err = ERR_REPEAT;
								end else if (size_q != '0 && rep_half == size_q) begin
									err = ERR_REPEAT;
								end else if (size_q == '0 && w != '0) begin
									err = ERR_REP_NOSMP;
								end
							end
							RB_LEN_LO: begin
								if (w > OLD_SIZE_MAX) old_n = 1'b0;
								if (w > SIZE_MAX) err = ERR_REPLEN;
							end
							default: ;
						endcase
					end
				end
				RG_SONGLEN: begin
					if (total_q < TOTAL_MIN) begin
						err = ERR_TOTAL;
					end else if (b == 8'd0 || b > ORDER_MAX) begin
						err = ERR_SONGLEN;
					end
				end
				RG_TEMPO: begin
					if (b < TEMPO_MIN) err = ERR_TEMPO;
				end
				RG_ORDER: begin
					if (b > ORDER_MAX) begin
						err = ERR_ORDER;
					end else if (b[6:0] > max_q) begin
						max_n = b[6:0];
					end
				end
				RG_PATTERN: begin
					if (q_item.blk <= {1'b0, max_q}) begin
						case (q_item.phase)
							EV_NOTE_HI: held_n = b;
							EV_NOTE_LO: begin
								if ((w & SAMPLE_MASK) != '0) begin
									err = ERR_SAMPLE;
								end else if (w != '0 && !period_valid(w)) begin
									err = ERR_PERIOD;
								end
							end
							EV_EFFECT: nib_n = b[3:0];
							default: begin
								if (nib_q != 4'd0) begin
									eff_bit = 16'd1 << nib_q;
								end else if (b != 8'd0) begin
									eff_bit = 16'd1;
								end
								eff_n = eff_q | eff_bit;
								if (nib_q == 4'd1 && b == 8'd0) old_n = 1'b0;
								if (nib_q == 4'd2 && b[7:4] != 4'd0 && b[3:0] != 4'd0) begin
									old_n = 1'b0;
								end
								if ((eff_n & NEW_FX_MASK) != '0) old_n = 1'b0;
							end
						endcase
					end
				end
				default: ;
			endcase
		end
		fe_n = (fe_q == ERR_NONE) ? err : fe_q;
	end

	// verdict of the final byte
	always_comb begin
		if (q_item.too_short) begin
			v = ERR_SHORT;
		end else if (fe_n != ERR_NONE) begin
			v = fe_n;
		end else if (q_item.end_blk <= {1'b0, max_n}) begin
			v = ERR_TRUNC;
		end else begin
			v = ERR_NONE;
		end
	end

	// check state, cleared after each file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			size_q  <= '0;
			total_q <= '0;
			max_q   <= '0;
			eff_q   <= '0;
			old_q   <= 1'b1;
			fe_q    <= ERR_NONE;
			nib_q   <= '0;
		end else if (pop) begin
			if (q_item.last) begin
				held_q  <= '0;
				size_q  <= '0;
				total_q <= '0;
				max_q   <= '0;
				eff_q   <= '0;
				old_q   <= 1'b1;
				fe_q    <= ERR_NONE;
				nib_q   <= '0;
			end else begin
				held_q  <= held_n;
				size_q  <= size_n;
				total_q <= total_n;
				max_q   <= max_n;
				eff_q   <= eff_n;
				old_q   <= old_n;
				fe_q    <= fe_n;
				nib_q   <= nib_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && q_item.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_item.last) begin
			verdict_q   <= v;
			old_out_q   <= (v == ERR_NONE) ? old_n : 1'b0;
			count_out_q <= {1'b0, max_n} + 8'd1;
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign is_old_variant = old_out_q;
	assign pattern_count  = count_out_q;

endmodule
